>>> rtl/iept_pkg.sv
// Shared types, packet codes and the remote key table for the input event translator.
// Used by every module of the block; depends on nothing.
package iept_pkg;

  localparam int ACCUM_WIDTH_DEF = 32;
  localparam int QUEUE_DEPTH_DEF = 4;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 10;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] CFG_HOTKEY_KEY   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_NEED_CTRL    = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_NEED_SHIFT   = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_NEED_ALT     = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_NEED_META    = 3'd4;

  // Event types and codes of the evdev protocol that the block decodes.
  localparam logic [4:0] EV_SYN = 5'd0;
  localparam logic [4:0] EV_KEY = 5'd1;
  localparam logic [4:0] EV_REL = 5'd2;

  localparam logic [9:0] SYN_RPT    = 10'd0;
  localparam logic [9:0] REL_X      = 10'd0;
  localparam logic [9:0] REL_Y      = 10'd1;
  localparam logic [9:0] REL_WHL    = 10'd8;
  localparam logic [9:0] MBTN_L     = 10'h110;
  localparam logic [9:0] MBTN_R     = 10'h111;
  localparam logic [9:0] MBTN_M     = 10'h112;
  localparam logic [9:0] KEY_LSHIFT = 10'd42;
  localparam logic [9:0] KEY_RSHIFT = 10'd54;
  localparam logic [9:0] KEY_LCTRL  = 10'd29;
  localparam logic [9:0] KEY_RCTRL  = 10'd97;
  localparam logic [9:0] KEY_LALT   = 10'd56;
  localparam logic [9:0] KEY_RALT   = 10'd100;
  localparam logic [9:0] KEY_LMETA  = 10'd125;
  localparam logic [9:0] KEY_RMETA  = 10'd126;

  // Result packet types.
  localparam logic [2:0] PKT_MOVE   = 3'd0;
  localparam logic [2:0] PKT_BUTTON = 3'd1;
  localparam logic [2:0] PKT_KEY    = 3'd2;
  localparam logic [2:0] PKT_WHEEL  = 3'd3;
  localparam logic [2:0] PKT_NOTICE = 3'd4;

  // Remote codes of the modifier releases sent when capture ends.
  localparam logic [7:0] VK_CTRL  = 8'h11;
  localparam logic [7:0] VK_SHF   = 8'h10;
  localparam logic [7:0] VK_ALT   = 8'h12;

  // Bit positions in the release mask, in emission order.
  localparam int REL_CTRL  = 0;
  localparam int REL_SHIFT = 1;
  localparam int REL_ALT   = 2;

  typedef struct packed {
    logic               from_mouse;
    logic [4:0]         ev_type;
    logic [9:0]         ev_code;
    logic signed [31:0] ev_value;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         pkt_type;
    logic signed [31:0] move_x;
    logic signed [31:0] move_y;
    logic [1:0]         button;
    logic               is_down;
    logic [7:0]         vk_code;
    logic signed [31:0] wheel_delta;
    logic               capture_on;
    logic               last;
  } out_item_t;

  // One classified event: releases still to send, then the main packet.
  typedef struct packed {
    logic [2:0] rel_mask;
    out_item_t  main;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  localparam int VK_TABLE_LEN = 140;

  localparam logic [7:0] VK_TABLE [VK_TABLE_LEN] = '{
    8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
    8'h37, 8'h38, 8'h39, 8'h30, 8'hBD, 8'hBB, 8'h08, 8'h09,
    8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
    8'h4F, 8'h50, 8'hDB, 8'hDD, 8'h0D, 8'hA2, 8'h41, 8'h53,
    8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'hBA,
    8'hDE, 8'hC0, 8'hA0, 8'hDC, 8'h5A, 8'h58, 8'h43, 8'h56,
    8'h42, 8'h4E, 8'h4D, 8'hBC, 8'hBE, 8'hBF, 8'hA1, 8'h6A,
    8'hA4, 8'h20, 8'h14, 8'h70, 8'h71, 8'h72, 8'h73, 8'h74,
    8'h75, 8'h76, 8'h77, 8'h78, 8'h79, 8'h90, 8'h91, 8'h67,
    8'h68, 8'h69, 8'h6D, 8'h64, 8'h65, 8'h66, 8'h6B, 8'h61,
    8'h62, 8'h63, 8'h60, 8'h6E, 8'h00, 8'h00, 8'h00, 8'h7A,
    8'h7B, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h0D, 8'hA3, 8'h6F, 8'h2C, 8'hA5, 8'h00, 8'h24, 8'h26,
    8'h21, 8'h25, 8'h27, 8'h23, 8'h28, 8'h22, 8'h2D, 8'h2E,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h13,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h5B, 8'h5C, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h5D
  };

  // Codes outside the table, or with an empty entry, pass their low byte.
  function automatic logic [7:0] map_key(input logic [9:0] code);
    logic [7:0] ent;
    ent = VK_TABLE[code[7:0]];
    if ((code < 10'(VK_TABLE_LEN)) && (ent != 8'h00)) begin
      return ent;
    end
    return code[7:0];
  endfunction

endpackage

>>> rtl/input_event_packet_translator.sv
// Top level of the input event packet translator.
// Instantiates iept_front, iept_cmd_queue and iept_back; uses iept_pkg.
//
// Usage: input event beats enter on in_valid/in_stall with in_item; result
// beats leave on out_valid/out_stall with out_item. A beat moves at a rising
// edge where valid is high and stall is low. The hotkey and its modifier
// requirements are written on cfg_valid/cfg_ready, which is always ready;
// write them only while no event is in flight.
//
// The front end updates modifier, capture and motion state in the cycle an
// event is taken and queues one command for each event that yields results.
// Such an event's command is written into the command queue and then into the
// output register, from which its first beat leaves.
// Events without results consume their input beat and nothing downstream.
// The back end sends one beat per cycle while out_stall is low. An event
// yields one beat, or up to four when capture ends with ctrl, shift and alt
// all held (three releases, then the notice); its final beat carries last.
//
// When the receiver stalls, the output register holds its beat, the back end
// stops draining, and in_stall rises once the QUEUE_DEPTH-entry command queue
// fills. Reset (synchronous, rst_n low) clears all state and capture, empties
// the queue and restores the hotkey to key 46 with alt required.
module input_event_packet_translator #(
  parameter int ACCUM_WIDTH = iept_pkg::ACCUM_WIDTH_DEF,
  parameter int QUEUE_DEPTH = iept_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  iept_pkg::in_item_t               in_item,
  output logic                             out_valid,
  input  logic                             out_stall,
  output iept_pkg::out_item_t              out_item,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [iept_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [iept_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import iept_pkg::*;

  q_status_t q_status;
  logic      push, pop;
  cmd_t      push_cmd, head_cmd;

  iept_front #(
    .ACCUM_WIDTH(ACCUM_WIDTH)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .q_status (q_status),
    .push     (push),
    .push_cmd (push_cmd)
  );

  // The queue lets the front end keep taking events while results wait.
  iept_cmd_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_cmd(push_cmd),
    .pop     (pop),
    .head_cmd(head_cmd),
    .status  (q_status)
  );

  iept_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head_cmd (head_cmd),
    .q_status (q_status),
    .pop      (pop),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item)
  );

endmodule

>>> rtl/iept_front.sv
// Front end: takes input event beats, tracks modifier, capture and motion state,
// and pushes one classified command per event that yields results. Uses iept_pkg.
module iept_front #(
  parameter int ACCUM_WIDTH = iept_pkg::ACCUM_WIDTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  iept_pkg::in_item_t                   in_item,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [iept_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [iept_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  iept_pkg::q_status_t                  q_status,
  output logic                                 push,
  output iept_pkg::cmd_t                       push_cmd
);
  import iept_pkg::*;

  localparam int SW = 33;
  localparam logic signed [SW-1:0] SAT_HI = SW'((64'sd1 <<< (ACCUM_WIDTH - 1)) - 64'sd1);
  localparam logic signed [SW-1:0] SAT_LO = -SAT_HI - SW'(1);

  logic [9:0] hotkey_key_r;
  logic       need_ctrl_r, need_shift_r, need_alt_r, need_meta_r;

  logic capturing_r, capturing_nxt;
  logic ctrl_r, ctrl_nxt, shift_r, shift_nxt, alt_r, alt_nxt, meta_r, meta_nxt;
  logic signed [ACCUM_WIDTH-1:0] acc_x_r, acc_x_nxt, acc_y_r, acc_y_nxt;

  logic               in_fire;
  logic [31:0]        raw;
  logic               por, down, kbd, hot, cmd_valid;
  logic signed [SW-1:0] sum_x, sum_y;
  logic signed [ACCUM_WIDTH-1:0] sat_x, sat_y;
  cmd_t               cmd;

  assign in_stall  = q_status.full;
  assign cfg_ready = 1'b1;
  assign in_fire   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hotkey_key_r <= 10'd46;
      need_ctrl_r  <= 1'b0;
      need_shift_r <= 1'b0;
      need_alt_r   <= 1'b1;
      need_meta_r  <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_HOTKEY_KEY: hotkey_key_r <= cfg_data;
        CFG_NEED_CTRL:  need_ctrl_r  <= cfg_data[0];
        CFG_NEED_SHIFT: need_shift_r <= cfg_data[0];
        CFG_NEED_ALT:   need_alt_r   <= cfg_data[0];
        CFG_NEED_META:  need_meta_r  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign raw  = in_item.ev_value;
  assign por  = (raw == 32'd0) || (raw == 32'd1);
  assign down = (raw == 32'd1);
  assign kbd  = !in_item.from_mouse;

  // Saturating adds are worked at 33 bits, one bit wider than the 32-bit event value.
  assign sum_x = SW'(acc_x_r) + SW'(in_item.ev_value);
  assign sum_y = SW'(acc_y_r) + SW'(in_item.ev_value);
  assign sat_x = (sum_x > SAT_HI) ? ACCUM_WIDTH'(SAT_HI) :
                 (sum_x < SAT_LO) ? ACCUM_WIDTH'(SAT_LO) : ACCUM_WIDTH'(sum_x);
  assign sat_y = (sum_y > SAT_HI) ? ACCUM_WIDTH'(SAT_HI) :
                 (sum_y < SAT_LO) ? ACCUM_WIDTH'(SAT_LO) : ACCUM_WIDTH'(sum_y);

  always_comb begin
    capturing_nxt = capturing_r;
    ctrl_nxt      = ctrl_r;
    shift_nxt     = shift_r;
    alt_nxt       = alt_r;
    meta_nxt      = meta_r;
    acc_x_nxt     = acc_x_r;
    acc_y_nxt     = acc_y_r;
    hot           = 1'b0;
    cmd_valid     = 1'b0;
    cmd           = '0;

    if (kbd) begin
      if (in_item.ev_type == EV_KEY) begin
        if (por) begin
          if (in_item.ev_code == KEY_LSHIFT || in_item.ev_code == KEY_RSHIFT) begin
            shift_nxt = down;
          end else if (in_item.ev_code == KEY_LCTRL || in_item.ev_code == KEY_RCTRL) begin
            ctrl_nxt = down;
          end else if (in_item.ev_code == KEY_LALT || in_item.ev_code == KEY_RALT) begin
            alt_nxt = down;
          end else if (in_item.ev_code == KEY_LMETA || in_item.ev_code == KEY_RMETA) begin
            meta_nxt = down;
          end
        end
        hot = down && (in_item.ev_code == hotkey_key_r) &&
              !(need_ctrl_r && !ctrl_nxt) && !(need_shift_r && !shift_nxt) &&
              !(need_alt_r && !alt_nxt) && !(need_meta_r && !meta_nxt);
        if (hot) begin
          cmd_valid          = 1'b1;
          cmd.main.pkt_type  = PKT_NOTICE;
          if (capturing_r) begin
            capturing_nxt           = 1'b0;
            cmd.rel_mask[REL_CTRL]  = ctrl_nxt;
            cmd.rel_mask[REL_SHIFT] = shift_nxt;
            cmd.rel_mask[REL_ALT]   = alt_nxt;
            ctrl_nxt  = 1'b0;
            shift_nxt = 1'b0;
            alt_nxt   = 1'b0;
          end else begin
            capturing_nxt = 1'b1;
          end
        end else if (capturing_r && por) begin
          cmd_valid         = 1'b1;
          cmd.main.pkt_type = PKT_KEY;
          cmd.main.is_down  = down;
          cmd.main.vk_code  = map_key(in_item.ev_code);
        end
      end
    end else if (in_item.ev_type == EV_REL) begin
      if (in_item.ev_code == REL_X) begin
        acc_x_nxt = sat_x;
      end else if (in_item.ev_code == REL_Y) begin
        acc_y_nxt = sat_y;
      end else if (in_item.ev_code == REL_WHL && capturing_r) begin
        cmd_valid            = 1'b1;
        cmd.main.pkt_type    = PKT_WHEEL;
        // Times 120 as 128 minus 8, wrapping at 32 bits.
        cmd.main.wheel_delta = (raw << 7) - (raw << 3);
      end
    end else if (in_item.ev_type == EV_KEY) begin
      if (capturing_r && por && in_item.ev_code >= MBTN_L &&
          in_item.ev_code <= MBTN_M) begin
        cmd_valid         = 1'b1;
        cmd.main.pkt_type = PKT_BUTTON;
        cmd.main.button   = 2'(in_item.ev_code - MBTN_L);
        cmd.main.is_down  = down;
      end
    end else if (in_item.ev_type == EV_SYN && in_item.ev_code == SYN_RPT) begin
      if (capturing_r && (acc_x_r != '0 || acc_y_r != '0)) begin
        cmd_valid         = 1'b1;
        cmd.main.pkt_type = PKT_MOVE;
        cmd.main.move_x   = 32'(acc_x_r);
        cmd.main.move_y   = 32'(acc_y_r);
      end
      acc_x_nxt = '0;
      acc_y_nxt = '0;
    end

    cmd.main.capture_on = capturing_nxt;
    cmd.main.last       = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capturing_r <= 1'b0;
      ctrl_r      <= 1'b0;
      shift_r     <= 1'b0;
      alt_r       <= 1'b0;
      meta_r      <= 1'b0;
      acc_x_r     <= '0;
      acc_y_r     <= '0;
    end else if (in_fire) begin
      capturing_r <= capturing_nxt;
      ctrl_r      <= ctrl_nxt;
      shift_r     <= shift_nxt;
      alt_r       <= alt_nxt;
      meta_r      <= meta_nxt;
      acc_x_r     <= acc_x_nxt;
      acc_y_r     <= acc_y_nxt;
    end
  end

  assign push     = in_fire && cmd_valid;
  assign push_cmd = cmd;

endmodule

>>> rtl/iept_cmd_queue.sv
// Short command queue between the front and back ends of the event translator.
// Holds cmd_t entries from iept_pkg; the head is read from a register array.
module iept_cmd_queue #(
  parameter int DEPTH = iept_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  iept_pkg::cmd_t      push_cmd,
  input  logic                pop,
  output iept_pkg::cmd_t      head_cmd,
  output iept_pkg::q_status_t status
);
  import iept_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t          mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  assign status.full  = (count_r == CW'(DEPTH));
  assign status.empty = (count_r == '0);
  assign head_cmd     = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) !(push && status.full))
    else $error("command pushed into a full queue");
  assert property (@(posedge clk) disable iff (!rst_n) !(pop && status.empty))
    else $error("command popped from an empty queue");

endmodule

>>> rtl/iept_back.sv
// Back end: expands the queue head into result beats, modifier releases first,
// and holds each beat in the output register. Uses iept_pkg.
module iept_back (
  input  logic                clk,
  input  logic                rst_n,
  input  iept_pkg::cmd_t      head_cmd,
  input  iept_pkg::q_status_t q_status,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output iept_pkg::out_item_t out_item
);
  import iept_pkg::*;

  logic [2:0] done_r, done_nxt;
  logic [2:0] remaining, low_bit;
  logic       out_valid_r, out_valid_nxt;
  out_item_t  out_item_r, item;
  logic       out_load, step;

  assign remaining = head_cmd.rel_mask & ~done_r;
  assign low_bit   = remaining & (~remaining + 3'd1);
  assign out_load  = !out_valid_r || !out_stall;
  assign step      = !q_status.empty && out_load;
  assign pop       = step && (remaining == 3'b000);

  always_comb begin
    item     = head_cmd.main;
    done_nxt = done_r;
    if (remaining != 3'b000) begin
      item            = '0;
      item.pkt_type   = PKT_KEY;
      item.is_down    = 1'b0;
      item.capture_on = head_cmd.main.capture_on;
      item.last       = 1'b0;
      if (low_bit[REL_CTRL]) begin
        item.vk_code = VK_CTRL;
      end else if (low_bit[REL_SHIFT]) begin
        item.vk_code = VK_SHF;
      end else begin
        item.vk_code = VK_ALT;
      end
      if (step) begin
        done_nxt = done_r | low_bit;
      end
    end else if (step) begin
      done_nxt = 3'b000;
    end
    out_valid_nxt = step ? 1'b1 : (out_stall ? out_valid_r : 1'b0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r      <= 3'b000;
      out_valid_r <= 1'b0;
    end else begin
      done_r      <= done_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_item_r <= item;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  assert property (@(posedge clk) disable iff (!rst_n)
    !q_status.empty |-> ((done_r & ~head_cmd.rel_mask) == 3'b000))
    else $error("release progress does not match the head command");
  assert property (@(posedge clk) disable iff (!rst_n) pop |=> (done_r == 3'b000))
    else $error("release progress not cleared after pop");
  assert property (@(posedge clk) disable iff (!rst_n)
    (step && !pop) |=> (out_valid_r && !out_item_r.last && out_item_r.pkt_type == PKT_KEY))
    else $error("modifier release beat malformed");

endmodule
